// File: rtl/rtd_pkg.sv
// Shared constants, coefficient table and types for the RTD code to temperature pipeline.
package rtd_pkg;

  localparam int unsigned RAW_W      = 15;
  localparam int unsigned REF_W      = 18;
  localparam int unsigned NOM_W      = 15;
  localparam int unsigned TEMP_W     = 20;
  localparam int unsigned MUL_W      = RAW_W + REF_W;
  localparam int unsigned RATIO_W    = 34;
  localparam int unsigned DIV_STEPS  = 34;
  localparam int unsigned SQRT_W     = 52;
  localparam int unsigned SQRT_STEPS = SQRT_W / 2;
  localparam int unsigned ROOT_W     = SQRT_STEPS;
  localparam int unsigned ACC_W      = 37;
  localparam int unsigned U_W        = 24;
  localparam int unsigned PROD_W     = ACC_W + U_W + 1;
  localparam int unsigned HORNER_N   = 5;
  localparam int unsigned TROOT_W    = 19;

  localparam logic [RATIO_W-1:0] ONE_Q30   = 34'd1073741824;
  localparam logic [RATIO_W-1:0] RATIO_CAP = 34'd8589934592;

  localparam logic [35:0]        ROOT_C   = 36'd56396484375;
  localparam logic [ROOT_W-1:0]  KROOT    = 26'd39083000;
  localparam logic [SQRT_W-1:0]  KROOT_SQ = 52'd1527480889000000;

  localparam logic [27:0] RECIP_231  = 28'd148743457;
  localparam logic [6:0]  ROUND_ADD  = 7'd115;
  localparam logic [6:0]  HUNDRED    = 7'd100;

  localparam logic signed [ACC_W-1:0] POLY_C5 = 37'sd549186952;
  localparam logic signed [ACC_W-1:0] POLY_COEF [1:HORNER_N] = '{
    -37'sd793280926,
    -37'sd1061248623,
    37'sd4442542372,
    37'sd29833916579,
    37'sd0
  };

  localparam logic signed [TEMP_W-1:0] T_MIN_CENTI = -20'sd24202;
  localparam logic signed [TEMP_W-1:0] T_MAX_CENTI = 20'sd338400;

  typedef enum logic {
    REG_REFERENCE = 1'b0,
    REG_NOMINAL   = 1'b1
  } rtd_reg_e;

  typedef struct packed {
    logic               ovf;
    logic [RATIO_W-1:0] quot;
  } rtd_ratio_t;

  typedef struct packed {
    logic              ok;
    logic [ROOT_W-1:0] root;
    logic [29:0]       ratio_lo;
  } rtd_root_t;

endpackage

// File: rtl/rtd_ratio_div.sv
// Ratio stage: code times reference resistor, then a bit-per-stage division by the nominal.
module rtd_ratio_div import rtd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_valid_i,
  input  logic [RAW_W-1:0] raw_i,
  input  logic [REF_W-1:0] ref_i,
  input  logic [NOM_W-1:0] nom_i,
  output logic             out_valid_o,
  output rtd_ratio_t       out_o
);

  logic [NOM_W-1:0]   nom_eff;
  logic [RAW_W-1:0]   raw_q;
  logic               raw_vld_q;
  logic [MUL_W-1:0]   mul_q;
  logic               mul_vld_q;
  logic [NOM_W-1:0]   rem_q  [0:DIV_STEPS];
  logic [RATIO_W-1:0] quo_q  [0:DIV_STEPS];
  logic               ovf_q  [0:DIV_STEPS];
  logic               vld_q  [0:DIV_STEPS];
  logic [13:0]        hi;

  assign nom_eff = (nom_i == '0) ? NOM_W'(1) : nom_i;
  assign hi      = mul_q[MUL_W-1:19];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_vld_q <= 1'b0;
      mul_vld_q <= 1'b0;
      vld_q[0]  <= 1'b0;
    end else if (en_i) begin
      raw_vld_q <= in_valid_i;
      mul_vld_q <= raw_vld_q;
      vld_q[0]  <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q    <= raw_i;
      mul_q    <= MUL_W'(raw_q) * MUL_W'(ref_i);
      rem_q[0] <= NOM_W'(hi);
      quo_q[0] <= {mul_q[18:0], 15'd0};
      ovf_q[0] <= ({1'b0, hi} >= nom_eff);
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [NOM_W:0] trial;
    logic           take;

    assign trial = {rem_q[k-1], quo_q[k-1][RATIO_W-1]};
    assign take  = (trial >= {1'b0, nom_eff});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? NOM_W'(trial - {1'b0, nom_eff}) : trial[NOM_W-1:0];
        quo_q[k] <= {quo_q[k-1][RATIO_W-2:0], take};
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign out_valid_o = vld_q[DIV_STEPS];
  assign out_o.ovf   = ovf_q[DIV_STEPS];
  assign out_o.quot  = quo_q[DIV_STEPS];

endmodule

// File: rtl/rtd_cvd_root.sv
// Root branch: clamp the ratio, form the Callendar-Van Dusen root argument and take its square root.
module rtd_cvd_root import rtd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       in_valid_i,
  input  rtd_ratio_t in_i,
  output logic       out_valid_o,
  output rtd_root_t  out_o
);

  logic [RATIO_W-1:0] r_q;
  logic               r_vld_q;
  logic [RATIO_W-1:0] d_q;
  logic               ge1_d_q;
  logic [29:0]        lo_d_q;
  logic               d_vld_q;
  logic [50:0]        p1_q;
  logic [53:0]        p2_q;
  logic               ge1_p_q;
  logic [29:0]        lo_p_q;
  logic               p_vld_q;
  logic [SQRT_W-1:0]  t_q;
  logic               ge1_t_q;
  logic [29:0]        lo_t_q;
  logic               t_vld_q;
  logic [SQRT_W-1:0]  rem_q [0:SQRT_STEPS];
  logic [SQRT_W-1:0]  res_q [0:SQRT_STEPS];
  logic               ok_q  [0:SQRT_STEPS];
  logic [29:0]        lo_q  [0:SQRT_STEPS];
  logic               vld_q [0:SQRT_STEPS];
  logic               r_ge1;

  assign r_ge1 = (r_q >= ONE_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
      p_vld_q  <= 1'b0;
      t_vld_q  <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      r_vld_q  <= in_valid_i;
      d_vld_q  <= r_vld_q;
      p_vld_q  <= d_vld_q;
      t_vld_q  <= p_vld_q;
      vld_q[0] <= t_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q      <= (in_i.ovf || (in_i.quot > RATIO_CAP)) ? RATIO_CAP : in_i.quot;
      d_q      <= r_ge1 ? (r_q - ONE_Q30) : (ONE_Q30 - r_q);
      ge1_d_q  <= r_ge1;
      lo_d_q   <= r_q[29:0];
      p1_q     <= 51'(ROOT_C) * 51'(d_q[32:18]);
      p2_q     <= 54'(ROOT_C) * 54'(d_q[17:0]);
      ge1_p_q  <= ge1_d_q;
      lo_p_q   <= lo_d_q;
      t_q      <= SQRT_W'(p1_q) + SQRT_W'(p2_q[53:18]);
      ge1_t_q  <= ge1_p_q;
      lo_t_q   <= lo_p_q;
      rem_q[0] <= ge1_t_q ? (KROOT_SQ - t_q) : (KROOT_SQ + t_q);
      res_q[0] <= '0;
      ok_q[0]  <= !(ge1_t_q && (t_q > KROOT_SQ));
      lo_q[0]  <= lo_t_q;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - k));
    logic [SQRT_W-1:0] trial;
    logic              take;

    assign trial = res_q[k-1] + BIT;
    assign take  = (rem_q[k-1] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? (rem_q[k-1] - trial) : rem_q[k-1];
        res_q[k] <= take ? ((res_q[k-1] >> 1) + BIT) : (res_q[k-1] >> 1);
        ok_q[k]  <= ok_q[k-1];
        lo_q[k]  <= lo_q[k-1];
      end
    end
  end

  assign out_valid_o    = vld_q[SQRT_STEPS];
  assign out_o.ok       = ok_q[SQRT_STEPS];
  assign out_o.root     = res_q[SQRT_STEPS][ROOT_W-1:0];
  assign out_o.ratio_lo = lo_q[SQRT_STEPS];

endmodule

// File: rtl/rtd_temp_calc.sv
// Final stages: root-branch scaling, Horner polynomial for the cold branch, select and clamp.
module rtd_temp_calc import rtd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     in_valid_i,
  input  rtd_root_t                in_i,
  output logic                     out_valid_o,
  output logic signed [TEMP_W-1:0] temperature_o,
  output logic                     in_range_o,
  output logic                     below_o
);

  localparam int unsigned NSTG = 2 * HORNER_N;

  typedef struct packed {
    logic               below;
    logic               ok;
    logic [U_W-1:0]     u;
    logic [TROOT_W-1:0] troot;
  } side_t;

  side_t                     side_q [0:NSTG];
  logic                      vld_q  [0:NSTG];
  logic [26:0]               n_q;
  logic [54:0]               rprod_q;
  logic signed [PROD_W-1:0]  prod_q [0:HORNER_N-1];
  logic signed [ACC_W-1:0]   acc_q  [1:HORNER_N];
  logic [36:0]               u_full;
  logic [ROOT_W-1:0]         kdiff;
  logic signed [ACC_W:0]     rnd;
  logic signed [ACC_W:0]     tpoly;
  logic signed [TEMP_W-1:0]  tsel;
  logic signed [TEMP_W-1:0]  temp_q;
  logic                      in_range_q;
  logic                      below_q;
  logic                      out_vld_q;

  assign u_full = 37'(in_i.ratio_lo) * 37'(HUNDRED);
  assign kdiff  = KROOT - in_i.root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0].below <= in_i.ok && (in_i.root > KROOT);
      side_q[0].ok    <= in_i.ok;
      side_q[0].u     <= u_full[36:13];
      side_q[0].troot <= '0;
      n_q             <= 27'({kdiff, 1'b0}) + 27'(ROUND_ADD);
    end
  end

  for (genvar j = 1; j <= NSTG; j++) begin : g_stage
    side_t side_d;

    always_comb begin
      side_d = side_q[j-1];
      if (j == 2) begin
        side_d.troot = rprod_q[53:35];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= side_d;
      end
    end

    if (j == 1) begin : g_rmul
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rprod_q <= 55'(n_q) * 55'(RECIP_231);
        end
      end
    end

    if ((j % 2) == 1) begin : g_mul
      localparam int unsigned K = (j - 1) / 2;
      logic signed [ACC_W-1:0] acc_src;
      logic signed [U_W:0]     u_sgn;

      if (K == 0) begin : g_first
        assign acc_src = POLY_C5;
      end else begin : g_next
        assign acc_src = acc_q[K];
      end
      assign u_sgn = {1'b0, side_q[j-1].u};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q[K] <= PROD_W'(acc_src) * PROD_W'(u_sgn);
        end
      end
    end else begin : g_add
      localparam int unsigned K = (j - 2) / 2;
      logic signed [PROD_W-1:0] shifted;

      assign shifted = prod_q[K] >>> 24;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          acc_q[K+1] <= POLY_COEF[K+1] + shifted[ACC_W-1:0];
        end
      end
    end
  end

  assign rnd   = (ACC_W+1)'(acc_q[HORNER_N]) + (ACC_W+1)'(524288);
  assign tpoly = (rnd >>> 20) + (ACC_W+1)'(T_MIN_CENTI);

  always_comb begin
    if (!side_q[NSTG].ok) begin
      tsel = T_MAX_CENTI;
    end else if (side_q[NSTG].below) begin
      if (tpoly < (ACC_W+1)'(T_MIN_CENTI)) begin
        tsel = T_MIN_CENTI;
      end else if (tpoly > (ACC_W+1)'(T_MAX_CENTI)) begin
        tsel = T_MAX_CENTI;
      end else begin
        tsel = tpoly[TEMP_W-1:0];
      end
    end else begin
      tsel = TEMP_W'(side_q[NSTG].troot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      temp_q     <= tsel;
      in_range_q <= side_q[NSTG].ok;
      below_q    <= side_q[NSTG].below;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign temperature_o = temp_q;
  assign in_range_o    = in_range_q;
  assign below_o       = below_q;

endmodule

// File: rtl/rtd_code_to_temperature.sv
// Top level of the pipelined RTD code to temperature converter with its register port.
// Usage:
// Each transfer on the input channel (in_valid_i, in_stall_o, raw_rtd_i) carries one
// 15-bit ratio code and yields exactly one transfer on the output channel (out_valid_o,
// out_stall_i, temperature_centi_o, in_range_o, below_zero_branch_o), in order.
// A new code can be taken in every cycle while in_stall_o is low, so throughput is
// one item per clock unless the output stalls. The path runs through the
// 34-stage ratio divider and the 26-stage square root, one result bit per stage.
// When the receiver holds out_stall_i with a result waiting, every stage holds its
// contents and in_stall_o is raised, so nothing is dropped or duplicated.
// The APB-style port holds the reference resistor at address 0 and the nominal
// resistance at address 4, both in 1/16 ohm; they should only be written while the
// pipeline is empty. Reset empties the pipeline and loads 430 ohm and 100 ohm.
module rtd_code_to_temperature import rtd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [RAW_W-1:0]         raw_rtd_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [TEMP_W-1:0] temperature_centi_o,
  output logic                     in_range_o,
  output logic                     below_zero_branch_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [REF_W-1:0] ref_q;
  logic [NOM_W-1:0] nom_q;
  logic             wr_en;
  logic             en;
  logic             div_vld;
  rtd_ratio_t       div_out;
  logic             root_vld;
  rtd_root_t        root_out;
  rtd_reg_e         reg_sel;

  assign reg_sel = rtd_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 18'd6880;
      nom_q <= 15'd1600;
    end else if (wr_en) begin
      case (reg_sel)
        REG_REFERENCE: ref_q <= pwdata[REF_W-1:0];
        REG_NOMINAL:   nom_q <= pwdata[NOM_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_REFERENCE: prdata = 32'(ref_q);
      REG_NOMINAL:   prdata = 32'(nom_q);
      default:       prdata = '0;
    endcase
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  rtd_ratio_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .raw_i       (raw_rtd_i),
    .ref_i       (ref_q),
    .nom_i       (nom_q),
    .out_valid_o (div_vld),
    .out_o       (div_out)
  );

  rtd_cvd_root u_root (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (div_vld),
    .in_i        (div_out),
    .out_valid_o (root_vld),
    .out_o       (root_out)
  );

  rtd_temp_calc u_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (root_vld),
    .in_i          (root_out),
    .out_valid_o   (out_valid_o),
    .temperature_o (temperature_centi_o),
    .in_range_o    (in_range_o),
    .below_o       (below_zero_branch_o)
  );

endmodule
